>>> design/baro_temp_pressure_compensation_unit_assert.svh
// Assertion macros for the barometric compensation unit.
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`ifndef SYNTH
`define BTPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define BTPC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define BTPC_ASSERT(lbl, prop, msg)
`define BTPC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

>>> design/btpc_pkg.sv
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants of the barometric compensation unit.
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned DIV_W           = 64;

  localparam logic [1:0] CFG_TEMP_TRIM  = 2'd0;
  localparam logic [1:0] CFG_PRESS_LOW  = 2'd1;
  localparam logic [1:0] CFG_PRESS_HIGH = 2'd2;
  localparam logic [1:0] CFG_PRESS_LAST = 2'd3;

  typedef struct packed {
    logic [19:0] adc_p;
    logic [31:0] fine;
    logic [31:0] temp;
  } fe_item_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  typedef struct packed {
    logic [15:0] p9;
    logic [63:0] hi;
    logic [63:0] lo;
  } press_trim_t;

  typedef struct packed {
    logic [31:0] temp;
    logic        inv;
    logic        neg;
  } div_side_t;

endpackage

>>> design/btpc_front.sv
// ----------------------------------------------------------------------------
// btpc_front
// Accepts raw samples and runs the 32-bit fine temperature pipeline.
// ----------------------------------------------------------------------------
module btpc_front import btpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  logic [19:0] raw_p_i,
  input  logic [19:0] raw_t_i,
  input  logic [47:0] temp_trim_i,
  input  q_stat_t     q_stat_i,
  output logic        push_o,
  output fe_item_t    item_o
);

  logic [31:0] t1, t2, t3;
  logic        en;
  logic [3:0]  vld_q, vld_d;
  logic [19:0] adc1_q, adc2_q, adc3_q, adc4_q;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [31:0] m1_q, m1_d, bb_q, bb_d;
  logic [31:0] tv1_q, tv1_d, m2_q, m2_d, bbs;
  logic [31:0] fine_q, fine_d, f5;

  assign t1 = {16'd0, temp_trim_i[15:0]};
  assign t2 = {{16{temp_trim_i[31]}}, temp_trim_i[31:16]};
  assign t3 = {{16{temp_trim_i[47]}}, temp_trim_i[47:32]};

  assign en        = !vld_q[3] || !q_stat_i.full;
  assign s_ready_o = en;
  assign push_o    = vld_q[3] && !q_stat_i.full;

  always_comb begin
    vld_d  = {vld_q[2:0], s_valid_i};
    a_d    = {15'd0, raw_t_i[19:3]} - {15'd0, t1[15:0], 1'b0};
    b_d    = {16'd0, raw_t_i[19:4]} - t1;
    m1_d   = a_q * t2;
    bb_d   = b_q * b_q;
    tv1_d  = 32'($signed(m1_q) >>> 11);
    bbs    = 32'($signed(bb_q) >>> 12);
    m2_d   = bbs * t3;
    fine_d = tv1_q + 32'($signed(m2_q) >>> 14);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adc1_q <= raw_p_i;
      a_q    <= a_d;
      b_q    <= b_d;
      adc2_q <= adc1_q;
      m1_q   <= m1_d;
      bb_q   <= bb_d;
      adc3_q <= adc2_q;
      tv1_q  <= tv1_d;
      m2_q   <= m2_d;
      adc4_q <= adc3_q;
      fine_q <= fine_d;
    end
  end

  // temperature = (fine * 5 + 128) >> 8
  assign f5 = (fine_q << 2) + fine_q + 32'd128;

  always_comb begin
    item_o.adc_p = adc4_q;
    item_o.fine  = fine_q;
    item_o.temp  = 32'($signed(f5) >>> 8);
  end

endmodule

>>> design/btpc_queue.sv
// ----------------------------------------------------------------------------
// btpc_queue
// Short register queue between the front and back pipelines.
// ----------------------------------------------------------------------------
module btpc_queue import btpc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  fe_item_t item_i,
  input  logic     pop_i,
  output q_stat_t  stat_o,
  output fe_item_t item_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  fe_item_t        mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.valid = (cnt_q != '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && stat_o.valid;
  assign item_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

>>> design/btpc_div.sv
// ----------------------------------------------------------------------------
// btpc_div
// Pipelined unsigned 64/64 restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module btpc_div import btpc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             vld_i,
  input  logic [DIV_W-1:0] nm_i,
  input  logic [DIV_W-1:0] dm_i,
  input  div_side_t        side_i,
  output logic             vld_o,
  output logic [DIV_W-1:0] quo_o,
  output div_side_t        side_o
);

  logic [DIV_W-1:0] rem_q  [DIV_W];
  logic [DIV_W-1:0] nq_q   [DIV_W];
  logic [DIV_W-1:0] dm_q   [DIV_W];
  div_side_t        side_q [DIV_W];
  logic [DIV_W-1:0] vld_q;

  logic [DIV_W-1:0] rem_in [DIV_W];
  logic [DIV_W-1:0] nq_in  [DIV_W];
  logic [DIV_W-1:0] dm_in  [DIV_W];
  div_side_t        side_in[DIV_W];
  logic [DIV_W:0]   sh     [DIV_W];
  logic [DIV_W-1:0] rem_d  [DIV_W];
  logic [DIV_W-1:0] nq_d   [DIV_W];
  logic [DIV_W-1:0] ge;

  always_comb begin
    rem_in[0]  = '0;
    nq_in[0]   = nm_i;
    dm_in[0]   = dm_i;
    side_in[0] = side_i;
    for (int k = 1; k < DIV_W; k++) begin
      rem_in[k]  = rem_q[k-1];
      nq_in[k]   = nq_q[k-1];
      dm_in[k]   = dm_q[k-1];
      side_in[k] = side_q[k-1];
    end
  end

  // shift in the next numerator bit, subtract when the divisor fits
  always_comb begin
    for (int k = 0; k < DIV_W; k++) begin
      sh[k]    = {rem_in[k], nq_in[k][DIV_W-1]};
      ge[k]    = (sh[k] >= {1'b0, dm_in[k]});
      rem_d[k] = ge[k] ? DIV_W'(sh[k] - {1'b0, dm_in[k]}) : sh[k][DIV_W-1:0];
      nq_d[k]  = {nq_in[k][DIV_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_W-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_W; k++) begin
        rem_q[k]  <= rem_d[k];
        nq_q[k]   <= nq_d[k];
        dm_q[k]   <= dm_in[k];
        side_q[k] <= side_in[k];
      end
    end
  end

  assign vld_o  = vld_q[DIV_W-1];
  assign quo_o  = nq_q[DIV_W-1];
  assign side_o = side_q[DIV_W-1];

endmodule

>>> design/btpc_back.sv
// ----------------------------------------------------------------------------
// btpc_back
// 64-bit pressure pipeline: trim products, division, final correction.
// ----------------------------------------------------------------------------
module btpc_back import btpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_stat_t     q_stat_i,
  input  fe_item_t    item_i,
  input  press_trim_t trim_i,
  output logic        pop_o,
  output logic        m_valid_o,
  input  logic        m_ready_i,
  output logic [31:0] temp_o,
  output logic [31:0] press_o,
  output logic        inv_o
);

  logic               en;
  logic [6:0]         pv_q;
  logic [4:0]         sv_q;
  logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0]        p1;

  // pre-division stages
  logic [19:0]        adc0_q, adc1_q, adc2_q, adc3_q;
  logic [31:0]        tmp0_q, tmp1_q, tmp2_q, tmp3_q, tmp4_q, tmp5_q;
  logic signed [33:0] v1_0_q;
  logic signed [67:0] sq_full;
  logic signed [63:0] sq_q, v2a_q, t3m_q, v2_q, v1b_q;
  logic signed [49:0] p5m_q, p5m2_q, p2m_q, p2m2_q;
  logic signed [63:0] p5m64, p2m64;
  logic [20:0]        pp21;
  logic [63:0]        prod_q, diff_q, num_q, den_q;
  logic [63:0]        nm_q, dm_q;
  div_side_t          side6_q, dside;
  logic               dvld;
  logic [63:0]        quo;

  // post-division stages
  logic signed [63:0] p7_q, p8_q, p9_q, p10_q;
  logic [31:0]        tmp7_q, tmp8_q, tmp9_q, tmp10_q;
  logic               inv7_q, inv8_q, inv9_q, inv10_q;
  logic signed [63:0] q13, q13_q, pq_q, p8p_q, p8p9_q, p8p10_q;
  logic [31:0]        pqhi_q, q13lo_q, cr1_q;
  logic [63:0]        ll_q, v1m_q;
  logic signed [63:0] fsum, fres;

  logic [31:0]        temp_q;
  logic [31:0]        press_q;
  logic               inv_q;

  assign p1 = {48'd0, trim_i.lo[15:0]};
  assign p2 = trim_i.lo[31:16];
  assign p3 = trim_i.lo[47:32];
  assign p4 = trim_i.lo[63:48];
  assign p5 = trim_i.hi[15:0];
  assign p6 = trim_i.hi[31:16];
  assign p7 = trim_i.hi[47:32];
  assign p8 = trim_i.hi[63:48];
  assign p9 = trim_i.p9;

  assign en        = !sv_q[4] || m_ready_i;
  assign pop_o     = en && q_stat_i.valid;
  assign m_valid_o = sv_q[4];
  assign temp_o    = temp_q;
  assign press_o   = press_q;
  assign inv_o     = inv_q;

  assign sq_full = v1_0_q * v1_0_q;
  assign p5m64   = p5m2_q;
  assign p2m64   = p2m2_q;
  assign pp21    = 21'd1048576 - {1'b0, adc3_q};
  assign q13     = p7_q >>> 13;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= '0;
      sv_q <= '0;
    end else if (en) begin
      pv_q <= {pv_q[5:0], q_stat_i.valid};
      sv_q <= {sv_q[3:0], dvld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // E0: center the fine temperature
      adc0_q <= item_i.adc_p;
      tmp0_q <= item_i.temp;
      v1_0_q <= $signed({{2{item_i.fine[31]}}, item_i.fine}) - 34'sd128000;
      // E1: square and first-order trims
      adc1_q <= adc0_q;
      tmp1_q <= tmp0_q;
      sq_q   <= sq_full[63:0];
      p5m_q  <= v1_0_q * p5;
      p2m_q  <= v1_0_q * p2;
      // E2: quadratic trims
      adc2_q <= adc1_q;
      tmp2_q <= tmp1_q;
      v2a_q  <= sq_q * p6;
      t3m_q  <= sq_q * p3;
      p5m2_q <= p5m_q;
      p2m2_q <= p2m_q;
      // E3: sums
      adc3_q <= adc2_q;
      tmp3_q <= tmp2_q;
      v2_q   <= v2a_q + (p5m64 <<< 17) + (64'(p4) <<< 35);
      v1b_q  <= (t3m_q >>> 8) + (p2m64 <<< 12);
      // E4: denominator product, numerator difference
      tmp4_q <= tmp3_q;
      prod_q <= (64'h0000_8000_0000_0000 + 64'(v1b_q)) * p1;
      diff_q <= ({43'd0, pp21} << 31) - 64'(v2_q);
      // E5
      tmp5_q <= tmp4_q;
      den_q  <= 64'($signed(prod_q) >>> 33);
      num_q  <= diff_q * 64'd3125;
      // E6: signs and magnitudes
      nm_q         <= num_q[63] ? 64'd0 - num_q : num_q;
      dm_q         <= den_q[63] ? 64'd0 - den_q : den_q;
      side6_q.temp <= tmp5_q;
      side6_q.inv  <= (den_q == 64'd0);
      side6_q.neg  <= num_q[63] ^ den_q[63];
      // E7: signed quotient
      p7_q   <= dside.neg ? $signed(64'd0 - quo) : $signed(quo);
      tmp7_q <= dside.temp;
      inv7_q <= dside.inv;
      // E8
      q13_q  <= q13;
      pq_q   <= q13 * p9;
      p8p_q  <= p7_q * p8;
      p8_q   <= p7_q;
      tmp8_q <= tmp7_q;
      inv8_q <= inv7_q;
      // E9: partial products of pq * q13, low 64 bits
      ll_q    <= pq_q[31:0] * q13_q[31:0];
      cr1_q   <= 32'(pq_q[31:0] * q13_q[63:32]);
      pqhi_q  <= pq_q[63:32];
      q13lo_q <= q13_q[31:0];
      p9_q    <= p8_q;
      p8p9_q  <= p8p_q;
      tmp9_q  <= tmp8_q;
      inv9_q  <= inv8_q;
      // E10
      v1m_q   <= ll_q + {cr1_q + 32'(pqhi_q * q13lo_q), 32'd0};
      p10_q   <= p9_q;
      p8p10_q <= p8p9_q;
      tmp10_q <= tmp9_q;
      inv10_q <= inv9_q;
      // E11: output register
      temp_q  <= tmp10_q;
      press_q <= inv10_q ? 32'd0 : fres[31:0];
      inv_q   <= inv10_q;
    end
  end

  always_comb begin
    fsum = p10_q + ($signed(v1m_q) >>> 25) + (p8p10_q >>> 19);
    fres = (fsum >>> 8) + (64'(p7) <<< 4);
  end

  btpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pv_q[6]),
    .nm_i   (nm_q),
    .dm_i   (dm_q),
    .side_i (side6_q),
    .vld_o  (dvld),
    .quo_o  (quo),
    .side_o (dside)
  );

endmodule

>>> design/baro_temp_pressure_compensation_unit.sv
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// Integer trim compensation of raw 20-bit pressure and temperature samples.
// One sample beat is accepted per clock and one result beat leaves per clock
// under no backpressure. Four front stages compute fine temperature, then the
// back runs seven stages of 64-bit trim products, a 64-stage divider (one
// quotient bit per stage) and five correction stages. Trims are to be written
// over the config channel only while no sample is in flight; the unit itself
// does not enforce this, since the config channel is always ready.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_unit_assert.svh"

module baro_temp_pressure_compensation_unit import btpc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // raw_pressure [19:0], raw_temperature [39:20]
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // temperature_centi [31:0], pressure_q8 [63:32]
  output logic [63:0] m_axis_tdata_o,
  // pressure_invalid [0]
  output logic [0:0]  m_axis_tuser_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [47:0] temp_trim_q;
  press_trim_t press_trim_q;
  q_stat_t     q_stat;
  fe_item_t    fe_item, q_item;
  logic        q_push, q_pop;
  logic [31:0] temp, press;
  logic        inv;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_trim_q  <= '0;
      press_trim_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TEMP_TRIM:  temp_trim_q     <= cfg_data_i[47:0];
        CFG_PRESS_LOW:  press_trim_q.lo <= cfg_data_i;
        CFG_PRESS_HIGH: press_trim_q.hi <= cfg_data_i;
        CFG_PRESS_LAST: press_trim_q.p9 <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  btpc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .raw_p_i     (s_axis_tdata_i[19:0]),
    .raw_t_i     (s_axis_tdata_i[39:20]),
    .temp_trim_i (temp_trim_q),
    .q_stat_i    (q_stat),
    .push_o      (q_push),
    .item_o      (fe_item)
  );

  btpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (fe_item),
    .pop_i  (q_pop),
    .stat_o (q_stat),
    .item_o (q_item)
  );

  btpc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_stat_i  (q_stat),
    .item_i    (q_item),
    .trim_i    (press_trim_q),
    .pop_o     (q_pop),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .temp_o    (temp),
    .press_o   (press),
    .inv_o     (inv)
  );

  assign m_axis_tdata_o = {press, temp};
  assign m_axis_tuser_o = inv;

  `BTPC_ASSERT_IMPL(a_inv_zero, m_axis_tvalid_o && m_axis_tuser_o[0], m_axis_tdata_o[63:32] == 32'd0, "invalid beat carries nonzero pressure")
  `BTPC_ASSERT_IMPL(a_stall_full, !s_axis_tready_o, q_stat.full, "input stalled while queue has room")
  `BTPC_ASSERT_IMPL(a_pop_drain, q_stat.valid && m_axis_tready_i, q_pop, "back idle while queue holds a beat")

endmodule
